>>> design/cci_pkg.sv
// ----------------------------------------------------------------------------
// cci_pkg
// shared types and constants for the column coincidence index block
// ----------------------------------------------------------------------------
package cci_pkg;

   localparam int MaxKeyLength = 16;
   localparam int AlphabetSize = 26;
   localparam int MaxText      = 4096;

   localparam int ColWidth   = $clog2(MaxKeyLength);
   localparam int LetWidth   = 5;
   localparam int CntWidth   = $clog2(MaxText) + 1;
   localparam int HistDepth  = MaxKeyLength * 32;
   localparam int HistAddrW  = $clog2(HistDepth);
   localparam int SumWidth   = 24;
   localparam int RatioWidth = 17;

   localparam logic [1:0] CsrKeyLength = 2'd0;

   typedef struct packed {
      logic [4:0] letter;
      logic       last_letter;
   } req_type;

   typedef struct packed {
      logic [3:0]            column;
      logic [SumWidth-1:0]   coincidence_sum;
      logic [SumWidth-1:0]   pair_count;
      logic [RatioWidth-1:0] ioc_ratio;
      logic                  ratio_valid;
      logic                  last_column;
   } rsp_type;

   // classified letter handed from front to back
   typedef struct packed {
      logic [ColWidth-1:0] col;
      logic [LetWidth-1:0] letter;
      logic                count;
      logic                last;
      logic [ColWidth:0]   len;
   } item_type;

endpackage

>>> design/cci_ram.sv
// ----------------------------------------------------------------------------
// cci_ram
// generic simple dual port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module cci_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> design/cci_divider.sv
// ----------------------------------------------------------------------------
// cci_divider
// restoring divider, one quotient bit per cycle, ratio in q1.16
// ----------------------------------------------------------------------------
module cci_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            go,
   input  logic [cci_pkg::SumWidth-1:0]    num,
   input  logic [cci_pkg::SumWidth-1:0]    den,
   output logic                            done,
   output logic [cci_pkg::RatioWidth-1:0]  quot
);
   import cci_pkg::*;

   localparam int Steps = SumWidth + 16;

   logic [SumWidth:0]       rem_ff, rem_in, trial;
   logic [Steps-1:0]        shq_ff, shq_in;
   logic [SumWidth-1:0]     den_ff, den_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic                    busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      shq_in  = shq_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[SumWidth-1:0], shq_ff[Steps-1]};
      if (go) begin
         rem_in  = '0;
         shq_in  = {num, 16'd0};
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            shq_in = {shq_ff[Steps-2:0], 1'b1};
         end else begin
            rem_in = trial;
            shq_in = {shq_ff[Steps-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(Steps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      shq_ff <= shq_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = (shq_ff > Steps'(65536)) ? RatioWidth'(65536) : shq_ff[RatioWidth-1:0];
endmodule

>>> design/cci_front.sv
// ----------------------------------------------------------------------------
// cci_front
// tracks the column position and classifies each letter
// ----------------------------------------------------------------------------
module cci_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  cci_pkg::req_type             req,
   input  logic [4:0]                   key_length,
   output logic                         push,
   output cci_pkg::item_type            item
);
   import cci_pkg::*;

   logic [ColWidth-1:0] pos_ff, pos_in, col;
   logic [ColWidth:0]   len, nxt;
   logic                push_ff;
   item_type            item_ff;

   always_comb begin
      if (key_length == 5'd0) begin
         len = (ColWidth+1)'(1);
      end else if (key_length > 5'(MaxKeyLength)) begin
         len = (ColWidth+1)'(MaxKeyLength);
      end else begin
         len = (ColWidth+1)'(key_length);
      end
      col = ({1'b0, pos_ff} >= len) ? '0 : pos_ff;
      nxt = {1'b0, col} + 1'b1;
      pos_in = pos_ff;
      if (accept) begin
         pos_in = (req.last_letter || nxt >= len) ? '0 : nxt[ColWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         push_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         push_ff <= accept;
      end
      item_ff.col    <= col;
      item_ff.letter <= req.letter;
      item_ff.count  <= req.letter < 5'(AlphabetSize);
      item_ff.last   <= req.last_letter;
      item_ff.len    <= len;
   end

   assign push = push_ff;
   assign item = item_ff;
endmodule

>>> design/cci_back.sv
// ----------------------------------------------------------------------------
// cci_back
// histogram update per letter, then per-column report and clearing sweep
// ----------------------------------------------------------------------------
module cci_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cci_pkg::item_type    item,
   output logic                 busy,
   output logic                 rsp_strobe,
   output cci_pkg::rsp_type     rsp
);
   import cci_pkg::*;

   typedef enum logic [2:0] {
      S_COUNT, S_READ, S_ACC, S_DIV, S_EMIT, S_CLR
   } state_type;

   state_type state_ff, state_in;

   // counting pipeline: stage 1 read, stage 2 write
   logic                 v1_ff, v1_in;
   item_type             i1_ff;
   logic [CntWidth-1:0]  tot_ff [MaxKeyLength];
   logic                 tv_ff [MaxKeyLength];
   logic [CntWidth-1:0]  tot1;

   logic                 we, bump;
   logic [HistAddrW-1:0] waddr, raddr, a1;
   logic [CntWidth-1:0]  wdata, rdata, hist1;
   logic                 fwd_ff;
   logic [CntWidth-1:0]  fwd_data_ff;
   logic [HistAddrW-1:0] fwd_addr_ff;
   logic [HistAddrW-1:0] clr_ff;

   logic [ColWidth:0]    len_ff;
   logic [ColWidth-1:0]  rcol_ff;
   logic [5:0]           let_ff;
   logic                 rd_v_ff;
   logic                 acc_v_ff;
   logic [CntWidth-1:0]  f_ff;
   logic [SumWidth-1:0]  sum_ff, pairs_ff;
   logic [2*CntWidth-1:0] fprod;
   logic                 div_go, div_done;
   logic [RatioWidth-1:0] quot;
   logic [CntWidth-1:0]  ncol;
   logic                 strobe_ff;
   rsp_type              rsp_ff;

   assign a1   = HistAddrW'({i1_ff.col, i1_ff.letter});
   assign tot1 = tv_ff[i1_ff.col] ? tot_ff[i1_ff.col] : '0;
   assign hist1 = (fwd_ff && fwd_addr_ff == a1) ? fwd_data_ff : rdata;
   assign bump = (state_ff == S_COUNT) && v1_ff && i1_ff.count
                 && tot1 < CntWidth'(MaxText);

   always_comb begin
      we = bump;
      waddr = a1;
      wdata = hist1 + 1'b1;
      raddr = HistAddrW'({item.col, item.letter});
      if (state_ff == S_CLR) begin
         we = 1'b1;
         waddr = clr_ff;
         wdata = '0;
      end else if (state_ff != S_COUNT) begin
         raddr = HistAddrW'({rcol_ff, let_ff[4:0]});
      end
   end

   cci_ram #(.Width(CntWidth), .Depth(HistDepth)) u_hist (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   cci_divider u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (sum_ff),
      .den   (pairs_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign ncol  = tv_ff[rcol_ff] ? tot_ff[rcol_ff] : '0;
   assign fprod = (acc_v_ff && f_ff >= CntWidth'(2)) ?
                  f_ff * (f_ff - 1'b1) : '0;
   assign div_go = (state_ff == S_ACC) && !acc_v_ff && let_ff == 6'(AlphabetSize + 2)
                   && ncol >= CntWidth'(2);

   always_comb begin
      state_in = state_ff;
      v1_in = push;
      case (state_ff)
         S_COUNT: begin
            if (v1_ff && i1_ff.last) begin
               state_in = S_READ;
               v1_in = 1'b0;
            end
         end
         S_READ:  state_in = S_ACC;
         S_ACC: begin
            if (let_ff == 6'(AlphabetSize + 2)) begin
               state_in = (ncol >= CntWidth'(2)) ? S_DIV : S_EMIT;
            end
         end
         S_DIV:   if (div_done) state_in = S_EMIT;
         S_EMIT: begin
            if ({1'b0, rcol_ff} + 1'b1 >= len_ff) begin
               state_in = S_CLR;
            end else begin
               state_in = S_READ;
            end
         end
         S_CLR: begin
            if (clr_ff == HistAddrW'(HistDepth - 1)) begin
               state_in = S_COUNT;
            end
         end
         default: state_in = S_COUNT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         v1_ff     <= 1'b0;
         fwd_ff    <= 1'b0;
         strobe_ff <= 1'b0;
         clr_ff    <= '0;
         for (int k = 0; k < MaxKeyLength; k++) tv_ff[k] <= 1'b0;
      end else begin
         state_ff  <= state_in;
         v1_ff     <= (state_ff == S_COUNT) ? v1_in : 1'b0;
         fwd_ff    <= we;
         strobe_ff <= (state_ff == S_EMIT);
         clr_ff    <= (state_ff == S_CLR) ? clr_ff + 1'b1 : '0;
         if (bump) begin
            tv_ff[i1_ff.col] <= 1'b1;
         end
         if (state_ff == S_EMIT && {1'b0, rcol_ff} + 1'b1 >= len_ff) begin
            for (int k = 0; k < MaxKeyLength; k++) tv_ff[k] <= 1'b0;
         end
      end
      i1_ff       <= item;
      fwd_data_ff <= wdata;
      fwd_addr_ff <= waddr;
      if (bump) begin
         tot_ff[i1_ff.col] <= tot1 + 1'b1;
      end
      rd_v_ff  <= (state_ff == S_ACC || state_ff == S_READ)
                  && let_ff < 6'(AlphabetSize);
      acc_v_ff <= rd_v_ff;
      f_ff     <= rdata;
      case (state_ff)
         S_COUNT: begin
            rcol_ff <= '0;
            let_ff  <= '0;
            len_ff  <= i1_ff.len;
            sum_ff  <= '0;
         end
         S_READ: begin
            let_ff <= let_ff + 6'd1;
            sum_ff <= '0;
         end
         S_ACC: begin
            if (let_ff != 6'(AlphabetSize + 2)) let_ff <= let_ff + 6'd1;
            sum_ff   <= sum_ff + SumWidth'(fprod);
            pairs_ff <= (ncol >= CntWidth'(2)) ?
                        SumWidth'(ncol) * (SumWidth'(ncol) - SumWidth'(1)) : '0;
         end
         S_EMIT: begin
            rsp_ff.column          <= 4'(rcol_ff);
            rsp_ff.coincidence_sum <= sum_ff;
            rsp_ff.pair_count      <= pairs_ff;
            rsp_ff.ioc_ratio       <= (ncol >= CntWidth'(2)) ? quot : '0;
            rsp_ff.ratio_valid     <= ncol >= CntWidth'(2);
            rsp_ff.last_column     <= {1'b0, rcol_ff} + 1'b1 >= len_ff;
            rcol_ff <= rcol_ff + 1'b1;
            let_ff  <= '0;
         end
         default: ;
      endcase
   end

   assign busy       = (state_ff != S_COUNT) || (v1_ff && i1_ff.last) || (push && item.last);
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   report_len: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> {1'b0, rsp_ff.column} < len_ff)
      else $error("report column beyond key length");
   valid_pairs: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && !rsp_ff.ratio_valid |-> rsp_ff.pair_count == '0)
      else $error("invalid column with pairs");
   ratio_cap: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> rsp_ff.ioc_ratio <= RatioWidth'(65536))
      else $error("ratio above one");
endmodule

>>> design/column_coincidence_index.sv
// ----------------------------------------------------------------------------
// column_coincidence_index
// per key column index of coincidence over a letter stream
// ----------------------------------------------------------------------------
// sequence: after the last letter is taken, each column in turn is scanned over
//   the histogram, divided when it holds two or more letters, then emitted;
//   a clear of all 512 histogram entries follows, busy until done; letters go
//   back to back while busy is low
// reset: synchronous, clears position and totals, key length 4, then runs the
//   histogram clear with busy high
module column_coincidence_index (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cci_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output cci_pkg::rsp_type  rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [1:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import cci_pkg::*;

   logic       key_ff;
   logic [4:0] key_length_ff;
   logic       accept, push;
   item_type   item;

   assign pready = 1'b1;
   assign prdata = (paddr == CsrKeyLength) ? {27'd0, key_length_ff} : '0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= 5'd4;
         key_ff        <= 1'b0;
      end else begin
         key_ff <= 1'b1;
         if (psel && penable && pwrite && paddr == CsrKeyLength) begin
            key_length_ff <= pwdata[4:0];
         end
      end
   end

   cci_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_item),
      .key_length (key_length_ff),
      .push       (push),
      .item       (item)
   );

   cci_back u_back (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .item       (item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_item)
   );

   strobe_busy: assert property (@(posedge clock) disable iff (reset || !key_ff)
      rsp_strobe |-> busy || $past(busy))
      else $error("report outside busy");
endmodule
